// File: hdl/gfau_pkg.sv
// Shared types, constants and the field multiply for the GF(2^8) arithmetic unit
`default_nettype none

package gfau_pkg;

   localparam int GF_WIDTH   = 8;
   localparam int CELL_COUNT = 8;

   localparam logic [GF_WIDTH-1:0]   POLY_RESET = 8'h1B;
   localparam logic [GF_WIDTH-1:0]   GF_ONE     = 8'h01;
   localparam logic [CELL_COUNT-1:0] INV_EXP    = 8'd254;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [GF_WIDTH-1:0] operand_a;
      logic [GF_WIDTH-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [GF_WIDTH-1:0] result;
      logic                div_by_zero;
   } rsp_type;

   typedef struct packed {
      mode_type            mode;
      logic [GF_WIDTH-1:0] operand_a;
      logic [GF_WIDTH-1:0] operand_b;
      logic [GF_WIDTH-1:0] acc;
      logic [GF_WIDTH-1:0] base;
   } cell_word_type;

   function automatic logic [GF_WIDTH-1:0] gf_mul(input logic [GF_WIDTH-1:0] a,
                                                 input logic [GF_WIDTH-1:0] b,
                                                 input logic [GF_WIDTH-1:0] poly);
      logic [GF_WIDTH-1:0] acc;
      acc = '0;
      for (int i = GF_WIDTH - 1; i >= 0; i--) begin
         acc = {acc[GF_WIDTH-2:0], 1'b0} ^ (acc[GF_WIDTH-1] ? poly : '0);
         if (a[i]) begin
            acc = acc ^ b;
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

// File: hdl/gfau_cell.sv
// One square-and-multiply cell of the inversion chain
`default_nettype none

module gfau_cell
   import gfau_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          exp_bit,
   input  wire logic [GF_WIDTH-1:0] poly,
   input  wire logic          in_valid,
   input  wire cell_word_type in_word,
   output logic               out_valid,
   output cell_word_type      out_word
);

   logic          valid_ff;
   logic          valid_in;
   cell_word_type word_ff;
   cell_word_type word_in;

   always_comb begin
      valid_in     = advance ? in_valid : valid_ff;
      word_in      = in_word;
      word_in.acc  = exp_bit ? gf_mul(in_word.acc, in_word.base, poly) : in_word.acc;
      word_in.base = gf_mul(in_word.base, in_word.base, poly);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

// File: hdl/gfau_out_stage.sv
// Final multiply, result register and skid buffer
`default_nettype none

module gfau_out_stage
   import gfau_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [GF_WIDTH-1:0] poly,
   input  wire logic          in_valid,
   input  wire cell_word_type in_word,
   output logic               advance,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_word
);

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_word_ff;
   rsp_type rsp_word_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_word_ff;
   rsp_type skid_word_in;
   rsp_type calc_word;
   logic [GF_WIDTH-1:0] mul_operand;
   logic    take;

   always_comb begin
      mul_operand = (in_word.mode == MODE_DIV) ? in_word.acc : in_word.operand_b;
      case (in_word.mode)
         MODE_ADD, MODE_SUB: begin
            calc_word.result = in_word.operand_a ^ in_word.operand_b;
         end
         MODE_MUL, MODE_DIV: begin
            calc_word.result = gf_mul(in_word.operand_a, mul_operand, poly);
         end
         default: begin
            calc_word.result = '0;
         end
      endcase
      calc_word.div_by_zero = (in_word.mode == MODE_DIV) && (in_word.operand_b == '0);
   end

   assign advance = !skid_valid_ff;
   assign take    = rsp_valid_ff && rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = calc_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = calc_word;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// File: hdl/gf256_arith_unit_core.sv
// Top level of the GF(2^8) arithmetic unit: inversion cell chain and output stage
// Throughput: one word per cycle while the skid buffer is empty; the eight-cell
// square-and-multiply chain forming b^254 is fully pipelined, followed by one
// multiply (an XOR for add and sub) into the output register.
// A one-word skid buffer keeps req_ready registered and independent of rsp_ready.
// Reset: synchronous, clears all valid bits and sets the reduction polynomial to 0x1B.
`default_nettype none

module gf256_arith_unit_core
   import gfau_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_wr_en,
   input  wire logic [GF_WIDTH-1:0] csr_wr_data,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_word,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_word
);

   logic [GF_WIDTH-1:0] reduction_poly_ff;
   logic [GF_WIDTH-1:0] reduction_poly_in;
   logic                advance;
   logic                chain_valid [CELL_COUNT+1];
   cell_word_type       chain_word  [CELL_COUNT+1];

   assign reduction_poly_in = csr_wr_en ? csr_wr_data : reduction_poly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reduction_poly_ff <= POLY_RESET;
      end else begin
         reduction_poly_ff <= reduction_poly_in;
      end
   end

   assign req_ready = advance;

   always_comb begin
      chain_valid[0]          = req_valid;
      chain_word[0].mode      = req_word.mode;
      chain_word[0].operand_a = req_word.operand_a;
      chain_word[0].operand_b = req_word.operand_b;
      chain_word[0].acc       = GF_ONE;
      chain_word[0].base      = req_word.operand_b;
   end

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      gfau_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .exp_bit   (INV_EXP[i]),
         .poly      (reduction_poly_ff),
         .in_valid  (chain_valid[i]),
         .in_word   (chain_word[i]),
         .out_valid (chain_valid[i+1]),
         .out_word  (chain_word[i+1])
      );
   end

   gfau_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .poly      (reduction_poly_ff),
      .in_valid  (chain_valid[CELL_COUNT]),
      .in_word   (chain_word[CELL_COUNT]),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// File: hdl/gfau_checker.sv
// Port-level assertions for the GF(2^8) arithmetic unit, bound to the top level
`default_nettype none

module gfau_checker
   import gfau_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_word
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response dropped or changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.div_by_zero |-> rsp_word.result == '0)
      else $error("zero-divisor response carries a non-zero result");

   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("reset did not empty the pipeline");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

endmodule

bind gf256_arith_unit_core gfau_checker u_gfau_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

`default_nettype wire
